// File: src/vr_pkg.sv
// Volume resampler package: register indexes, command and status codes.
// No dependencies.
`default_nettype none
package vr_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_DEPTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_DEPTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER     = 3'd6;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic FILTER_NEAREST   = 1'b0;
    localparam logic FILTER_TRILINEAR = 1'b1;

    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 32;

    typedef logic [16:0] t_weight;
endpackage
`default_nettype wire

// File: src/vr_ram.sv
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
`default_nettype none
module vr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: src/volume_resampler.sv
// Volume resampler top level: config registers, shared divider/shift-add unit,
// voxel store fetch sequencer and shared blend multiplier.
// Depends on vr_pkg and vr_ram.
//
//  port group     dir   content
//  s_axis_*       in    load / sample transaction, command in tuser
//  m_axis_*       out   sampled RGBA, status in tuser
//  i_cfg_*        in    register writes
//
// A sample runs three axes in turn (bit-serial divide of src<<48 by dst over NUMW
// quotient bits, then shift-add by the 16-bit coordinate), then fetches 1 or 8
// voxels on the single store port, then uses the shared blend multiplier in
// trilinear mode (NUMW = 54 at 32). An out-of-range request is answered from
// idle without running a sample. s_axis_tready is low while a sample runs or a
// result waits. Reset clears control state only; the store is not cleared.
`default_nettype none
module volume_resampler #(
    parameter int unsigned SRC_MAX_DIM = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // load_x[4:0] load_y[9:5] load_z[14:10] voxel_rgba[46:15]
    // dst_u[62:47] dst_v[78:63] dst_w[94:79], zero fill
    input  wire logic [vr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command[0]
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // red[7:0] green[15:8] blue[23:16] alpha[31:24]
    output logic [vr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status[0]
    output logic                                m_axis_tuser,
    input  wire logic                           i_cfg_we,
    input  wire logic [vr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [vr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import vr_pkg::*;

    localparam int unsigned IW    = $clog2(SRC_MAX_DIM);
    localparam int unsigned SW    = $clog2(SRC_MAX_DIM + 1);
    localparam int unsigned CW    = (SW > 6) ? SW : 6;
    localparam int unsigned NUMW  = SW + 48;
    localparam int unsigned TW    = NUMW - 32;
    localparam int unsigned DEPTH = SRC_MAX_DIM * SRC_MAX_DIM * SRC_MAX_DIM;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CNTW  = $clog2(NUMW + 1);
    localparam int unsigned AOPW  = 42;
    localparam int unsigned PRW   = 59;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_POS   = 3'd3;
    localparam logic [2:0] ST_AXIS  = 3'd4;
    localparam logic [2:0] ST_FETCH = 3'd5;
    localparam logic [2:0] ST_BLEND = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    function automatic logic [SW-1:0] eff_src(input logic [5:0] s);
        logic [CW-1:0] e;
        e = CW'(s);
        if (e == '0) begin
            e = CW'(1);
        end else if (e > CW'(SRC_MAX_DIM)) begin
            e = CW'(SRC_MAX_DIM);
        end
        return e[SW-1:0];
    endfunction

    // config
    logic [5:0]  r_src_w, r_src_h, r_src_d;
    logic [15:0] r_dst_w, r_dst_h, r_dst_d;
    logic        r_filter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= 6'd32;
            r_src_h  <= 6'd32;
            r_src_d  <= 6'd32;
            r_dst_w  <= 16'd32;
            r_dst_h  <= 16'd32;
            r_dst_d  <= 16'd32;
            r_filter <= FILTER_TRILINEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_w  <= i_cfg_data[5:0];
                CFG_SRC_HEIGHT: r_src_h  <= i_cfg_data[5:0];
                CFG_SRC_DEPTH:  r_src_d  <= i_cfg_data[5:0];
                CFG_DST_WIDTH:  r_dst_w  <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h  <= i_cfg_data;
                CFG_DST_DEPTH:  r_dst_d  <= i_cfg_data;
                CFG_FILTER:     r_filter <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [4:0]  in_x, in_y, in_z;
    logic [31:0] in_rgba;
    logic [15:0] in_u, in_v, in_w;
    assign in_x    = s_axis_tdata[4:0];
    assign in_y    = s_axis_tdata[9:5];
    assign in_z    = s_axis_tdata[14:10];
    assign in_rgba = s_axis_tdata[46:15];
    assign in_u    = s_axis_tdata[62:47];
    assign in_v    = s_axis_tdata[78:63];
    assign in_w    = s_axis_tdata[94:79];

    logic r_unused_ok;
    assign r_unused_ok = ^s_axis_tdata[95:95];

    // control / datapath registers
    logic [2:0]      r_state;
    logic [1:0]      r_axis;
    logic [CNTW-1:0] r_cnt;
    logic [15:0]     r_coord [3];
    logic [NUMW-1:0] r_num, r_quo, r_pos;
    logic [15:0]     r_rem, r_mbits;
    logic [IW-1:0]   r_i1 [3];
    logic [IW-1:0]   r_i2 [3];
    logic [15:0]     r_f  [3];
    logic [31:0]     r_px [8];
    logic [3:0]      r_p;
    logic [1:0]      r_ch;
    logic            r_phase;
    logic [PRW-1:0]  r_prod, r_acc;
    logic [AOPW-1:0] r_cx [4];
    logic [AOPW-1:0] r_cy [2];
    logic [7:0]      r_rgba [4];
    logic            r_out_valid, r_out_status;
    logic [31:0]     r_out_data;

    logic accept, req, load_ok, out_range;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign req       = (s_axis_tuser == CMD_SAMPLE);
    assign out_range = (in_u >= r_dst_w) || (in_v >= r_dst_h) || (in_w >= r_dst_d);
    assign load_ok   = ({27'b0, in_x} < 32'(SRC_MAX_DIM)) && ({27'b0, in_y} < 32'(SRC_MAX_DIM))
                    && ({27'b0, in_z} < 32'(SRC_MAX_DIM));

    // per-axis selection
    logic [SW-1:0] cur_src, smax;
    logic [15:0]   cur_dst;
    always_comb begin
        case (r_axis)
            2'd0:    begin cur_src = eff_src(r_src_w); cur_dst = r_dst_w; end
            2'd1:    begin cur_src = eff_src(r_src_h); cur_dst = r_dst_h; end
            default: begin cur_src = eff_src(r_src_d); cur_dst = r_dst_d; end
        endcase
        smax = cur_src - SW'(1);
    end

    // divider step
    logic [16:0] div_t;
    logic        div_ge;
    assign div_t  = {r_rem, r_num[NUMW-1]};
    assign div_ge = div_t >= {1'b0, cur_dst};

    // axis split
    logic [TW-1:0] tt, tm;
    logic [SW-1:0] a_raw, a_cl, b_cl, k_raw, k_cl;
    logic [SW:0]   a_inc;
    always_comb begin
        tt    = r_pos[NUMW-1:32];
        tm    = (tt > TW'(32'h8000)) ? tt - TW'(32'h8000) : '0;
        a_raw = tm[TW-1:16];
        a_cl  = (a_raw > smax) ? smax : a_raw;
        a_inc = {1'b0, a_cl} + (SW+1)'(1);
        b_cl  = (a_inc > {1'b0, smax}) ? smax : a_inc[SW-1:0];
        k_raw = r_pos[NUMW-1:48];
        k_cl  = (k_raw > smax) ? smax : k_raw;
    end

    // store
    logic          ram_we;
    logic [AW-1:0] ram_addr, fetch_addr, load_addr;
    logic [31:0]   ram_rdata;
    logic [2:0]    fk;
    logic [IW-1:0] fx, fy, fz;
    logic [CNTW-1:0] n_fetch;

    assign fk = r_cnt[2:0];
    assign fx = fk[0] ? r_i2[0] : r_i1[0];
    assign fy = fk[1] ? r_i2[1] : r_i1[1];
    assign fz = fk[2] ? r_i2[2] : r_i1[2];
    assign fetch_addr = AW'(fz) * AW'(SRC_MAX_DIM * SRC_MAX_DIM)
                      + AW'(fy) * AW'(SRC_MAX_DIM) + AW'(fx);
    assign load_addr  = AW'(in_z) * AW'(SRC_MAX_DIM * SRC_MAX_DIM)
                      + AW'(in_y) * AW'(SRC_MAX_DIM) + AW'(in_x);
    assign ram_we     = accept && !req && load_ok;
    assign ram_addr   = (r_state == ST_IDLE) ? load_addr : fetch_addr;
    assign n_fetch    = (r_filter == FILTER_TRILINEAR) ? CNTW'(8) : CNTW'(1);

    vr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(in_rgba),
        .o_rdata(ram_rdata)
    );

    // blend operands: x lerps, then y lerps, then z
    logic [AOPW-1:0] op_a;
    logic [15:0]     wf;
    t_weight         op_b;
    logic [PRW-1:0]  sum, rnd;
    always_comb begin
        if (r_p < 4'd8) begin
            op_a = AOPW'(r_px[r_p[2:0]][8*r_ch +: 8]);
            wf   = r_f[0];
        end else if (r_p < 4'd12) begin
            op_a = r_cx[r_p[1:0]];
            wf   = r_f[1];
        end else begin
            op_a = r_cy[r_p[0]];
            wf   = r_f[2];
        end
        op_b = r_p[0] ? {1'b0, wf} : 17'h10000 - {1'b0, wf};
        sum  = r_p[0] ? r_acc + r_prod : r_prod;
        rnd  = sum + (PRW'(1) << 47);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && req) begin
                        if (out_range) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= STATUS_RANGE;
                            r_out_data   <= '0;
                        end else begin
                            r_coord[0] <= in_u;
                            r_coord[1] <= in_v;
                            r_coord[2] <= in_w;
                            r_axis     <= 2'd0;
                            r_num      <= {eff_src(r_src_w), 48'b0};
                            r_rem      <= '0;
                            r_quo      <= '0;
                            r_cnt      <= '0;
                            r_state    <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_num <= r_num << 1;
                    r_quo <= {r_quo[NUMW-2:0], div_ge};
                    r_rem <= div_ge ? 16'(div_t - {1'b0, cur_dst}) : div_t[15:0];
                    if (r_cnt == CNTW'(NUMW - 1)) begin
                        r_cnt   <= '0;
                        r_pos   <= '0;
                        r_mbits <= r_coord[r_axis];
                        r_state <= ST_MUL;
                    end else begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                ST_MUL: begin
                    r_pos   <= (r_pos << 1) + (r_mbits[15] ? r_quo : '0);
                    r_mbits <= r_mbits << 1;
                    if (r_cnt == CNTW'(15)) begin
                        r_state <= ST_POS;
                    end
                    r_cnt <= r_cnt + CNTW'(1);
                end
                ST_POS: begin
                    r_pos   <= r_pos + (r_quo >> 1) - NUMW'(1);
                    r_state <= ST_AXIS;
                end
                ST_AXIS: begin
                    r_i1[r_axis] <= (r_filter == FILTER_TRILINEAR) ? a_cl[IW-1:0] : k_cl[IW-1:0];
                    r_i2[r_axis] <= b_cl[IW-1:0];
                    r_f[r_axis]  <= tm[15:0];
                    r_cnt        <= '0;
                    if (r_axis == 2'd2) begin
                        r_state <= ST_FETCH;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_num   <= {(r_axis == 2'd0) ? eff_src(r_src_h) : eff_src(r_src_d),
                                    48'b0};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_FETCH: begin
                    // address for voxel cnt issued; registered data of the previous address captured into r_px[cnt-1]
                    if (r_cnt != '0) begin
                        r_px[3'(r_cnt - CNTW'(1))] <= ram_rdata;
                    end
                    if (r_cnt == n_fetch) begin
                        r_p     <= '0;
                        r_ch    <= '0;
                        r_phase <= 1'b0;
                        r_state <= (r_filter == FILTER_TRILINEAR) ? ST_BLEND : ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                ST_BLEND: begin
                    r_phase <= !r_phase;
                    if (!r_phase) begin
                        r_prod <= PRW'(op_a * op_b);
                    end else begin
                        r_acc <= sum;
                        if (r_p[0]) begin
                            if (r_p < 4'd8) begin
                                r_cx[r_p[2:1]] <= sum[AOPW-1:0];
                            end else if (r_p < 4'd12) begin
                                r_cy[r_p[1]] <= sum[AOPW-1:0];
                            end else begin
                                r_rgba[r_ch] <= (rnd[PRW-1:56] != '0) ? 8'hff : rnd[55:48];
                            end
                        end
                        if (r_p == 4'd13) begin
                            r_p <= '0;
                            if (r_ch == 2'd3) begin
                                r_state <= ST_DONE;
                            end
                            r_ch <= r_ch + 2'd1;
                        end else begin
                            r_p <= r_p + 4'd1;
                        end
                    end
                end
                ST_DONE: begin
                    r_out_valid  <= 1'b1;
                    r_out_status <= STATUS_OK;
                    r_out_data   <= (r_filter == FILTER_TRILINEAR)
                                  ? {r_rgba[3], r_rgba[2], r_rgba[1], r_rgba[0]} : r_px[0];
                    r_state      <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // range errors carry zero channels
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == STATUS_RANGE) |-> (r_out_data == '0))
        else $error("range error with nonzero channels");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input ready while sample in flight");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && m_axis_tready |=> !r_out_valid)
        else $error("result repeated after transaction");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_out_valid && (r_state == ST_IDLE))
        else $error("finished sample not presented");

    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_unused_ok == s_axis_tdata[95]))
        else $error("pad bit check");
endmodule
`default_nettype wire
